FILE: rtl/u16u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam int UNIT_W   = 16;
   localparam int LEN_W    = 16;
   localparam int CP_W     = 21;
   localparam int NBYTES_W = 3;

   localparam logic [LEN_W-1:0] LIMIT_RESET = 16'hFFFF;
   localparam logic [LEN_W-1:0] LEN_MAX     = 16'hFFFF;

   // upper six bits of the surrogate ranges
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
   localparam logic [CP_W-1:0] CP_2BYTE  = 21'h000080;
   localparam logic [CP_W-1:0] CP_3BYTE  = 21'h000800;
   localparam logic [CP_W-1:0] CP_4BYTE  = 21'h010000;

   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] CONT   = 8'h80;
   localparam logic [5:0] CONT_MASK = 6'h3F;

   typedef enum logic [1:0] {
      STATUS_BUSY      = 2'd0,
      STATUS_DONE      = 2'd1,
      STATUS_BAD_PAIR  = 2'd2,
      STATUS_DANGLING  = 2'd3
   } status_type;

   // one group of results for one request
   typedef struct packed {
      logic [3:0][7:0]       bytes;      // byte 0 goes out first
      logic [NBYTES_W-1:0]   nbytes;     // 0 means one status-only result
      logic [LEN_W-1:0]      length;
      logic                  truncated;
      status_type            status;
   } group_type;

endpackage

FILE: rtl/utf16_to_utf8_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Streams UTF-16 code units in and UTF-8 bytes with string status out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one code unit per request, req_tlast marks the end of a
//          string. rsp_* carries one result per byte, or one status-only
//          result (rsp_tuser low) when a unit yields no byte; rsp_tlast
//          marks the final result of each request.
//   csr_wr_en / csr_wr_data set the destination byte limit (reset 65535);
//          write it only while no request is in flight.
//   A request accepted into the input register moves on to the result
//          register once that is free, and its first result is driven on the
//          response channel from the result register.
//   Throughput: one request per cycle while each yields a single result
//          and rsp_tready stays high; a unit that encodes to n bytes holds the
//          result register until all n bytes are taken, so the next unit waits.
//   Reset clears the per-string state and sets the byte limit to 65535.
//   When rsp_tready is low the result register holds and, once the input
//          register is also full, req_tready drops.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
   import u16u8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // code_unit[15:0]
   input  logic                req_tlast,   // last_unit
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // out_byte[7:0], encoded_length[23:8],
                                            // truncated[24], status[26:25], zero pad
   output logic                rsp_tuser,   // byte_valid
   output logic                rsp_tlast,   // last_of_run
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   logic              in_valid_ff;
   logic [UNIT_W-1:0] in_unit_ff;
   logic              in_last_ff;
   logic              load_ok, fire;
   group_type         group;

   assign fire       = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || load_ok;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   u16u8_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .unit        (in_unit_ff),
      .last        (in_last_ff),
      .group       (group)
   );

   u16u8_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .group      (group),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/u16u8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_core
// Surrogate pairing, length accounting, limit check and UTF-8 byte forming
// for one registered code unit; holds the per-string state and the limit.
// ----------------------------------------------------------------------------
module u16u8_core
   import u16u8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data,
   input  logic                fire,
   input  logic [UNIT_W-1:0]   unit,
   input  logic                last,
   output group_type           group
);

   logic [LEN_W-1:0] limit_ff;
   logic [9:0]       hi_ff, hi_in;
   logic             pend_ff, pend_in;
   logic [LEN_W-1:0] written_ff, written_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic             stop_ff, stop_in;
   logic             err_ff, err_in;

   logic             is_high, is_low, have;
   logic [CP_W-1:0]  cp;
   logic [NBYTES_W-1:0] n, nout;
   logic [LEN_W:0]   total_sum, written_sum;
   logic [3:0][7:0]  enc;
   status_type       status;

   assign is_high = (unit[15:10] == HIGH_SURR_TAG);
   assign is_low  = (unit[15:10] == LOW_SURR_TAG);

   // surrogate pairing
   always_comb begin
      hi_in   = hi_ff;
      pend_in = pend_ff;
      err_in  = err_ff;
      have    = 1'b0;
      cp      = '0;
      if (!err_ff) begin
         if (!pend_ff) begin
            if (is_high) begin
               hi_in   = unit[9:0];
               pend_in = 1'b1;
            end else begin
               cp   = {5'd0, unit};
               have = 1'b1;
            end
         end else if (is_low) begin
            cp      = {1'b0, hi_ff, unit[9:0]} + SUPP_BASE;
            hi_in   = '0;
            pend_in = 1'b0;
            have    = 1'b1;
         end else begin
            err_in  = 1'b1;
            hi_in   = '0;
            pend_in = 1'b0;
         end
      end
   end

   // encoded size
   always_comb begin
      if (cp < CP_2BYTE)      n = 3'd1;
      else if (cp < CP_3BYTE) n = 3'd2;
      else if (cp < CP_4BYTE) n = 3'd3;
      else                    n = 3'd4;
   end

   // byte forming
   always_comb begin
      enc = '0;
      case (n)
         3'd1: enc[0] = cp[7:0];
         3'd2: begin
            enc[0] = LEAD_2 | {3'd0, cp[10:6]};
            enc[1] = CONT | {2'd0, cp[5:0] & CONT_MASK};
         end
         3'd3: begin
            enc[0] = LEAD_3 | {4'd0, cp[15:12]};
            enc[1] = CONT | {2'd0, cp[11:6]};
            enc[2] = CONT | {2'd0, cp[5:0]};
         end
         default: begin
            enc[0] = LEAD_4 | {5'd0, cp[20:18]};
            enc[1] = CONT | {2'd0, cp[17:12]};
            enc[2] = CONT | {2'd0, cp[11:6]};
            enc[3] = CONT | {2'd0, cp[5:0]};
         end
      endcase
   end

   // length total and limit check
   assign total_sum   = {1'b0, total_ff} + {{(LEN_W-NBYTES_W+1){1'b0}}, n};
   assign written_sum = {1'b0, written_ff} + {{(LEN_W-NBYTES_W+1){1'b0}}, n};

   always_comb begin
      total_in   = total_ff;
      written_in = written_ff;
      stop_in    = stop_ff;
      nout       = '0;
      if (have) begin
         total_in = total_sum[LEN_W] ? LEN_MAX : total_sum[LEN_W-1:0];
         if (!stop_ff) begin
            if (written_sum > {1'b0, limit_ff}) begin
               stop_in = 1'b1;
            end else begin
               nout       = n;
               written_in = written_sum[LEN_W-1:0];
            end
         end
      end
   end

   always_comb begin
      if (err_in)    status = STATUS_BAD_PAIR;
      else if (last) status = pend_in ? STATUS_DANGLING : STATUS_DONE;
      else           status = STATUS_BUSY;
   end

   assign group.bytes     = (nout != '0) ? enc : '0;
   assign group.nbytes    = nout;
   assign group.length    = total_in;
   assign group.truncated = stop_in;
   assign group.status    = status;

   // byte limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // per-string state, cleared after the last unit
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff      <= '0;
         pend_ff    <= 1'b0;
         written_ff <= '0;
         total_ff   <= '0;
         stop_ff    <= 1'b0;
         err_ff     <= 1'b0;
      end else if (fire) begin
         if (last) begin
            hi_ff      <= '0;
            pend_ff    <= 1'b0;
            written_ff <= '0;
            total_ff   <= '0;
            stop_ff    <= 1'b0;
            err_ff     <= 1'b0;
         end else begin
            hi_ff      <= hi_in;
            pend_ff    <= pend_in;
            written_ff <= written_in;
            total_ff   <= total_in;
            stop_ff    <= stop_in;
            err_ff     <= err_in;
         end
      end
   end

   // a held surrogate is dropped as soon as an error is flagged
   assert property (@(posedge clock) disable iff (reset) err_ff |-> !pend_ff)
      else $error("surrogate held after pairing error");

endmodule

FILE: rtl/u16u8_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_serializer
// Result register that holds one group of up to four bytes and hands them
// to the response channel one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module u16u8_serializer
   import u16u8_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  group_type    group,
   output logic         load_ok,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // out_byte[7:0], encoded_length[23:8],
                                     // truncated[24], status[26:25], zero pad
   output logic         rsp_tuser,   // byte_valid
   output logic         rsp_tlast    // last_of_run
);

   logic       busy_ff, busy_in;
   group_type  grp_ff;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] top_ff;
   logic       at_end, take;

   assign at_end  = (idx_ff == top_ff);
   assign take    = busy_ff && rsp_tready;
   assign load_ok = !busy_ff || (take && at_end);

   // index and busy control
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take) begin
         if (at_end) busy_in = 1'b0;
         else        idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
         top_ff <= (group.nbytes == '0) ? 2'd0 : 2'(group.nbytes - 3'd1);
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {5'd0, grp_ff.status, grp_ff.truncated, grp_ff.length,
                        grp_ff.bytes[idx_ff]};
   assign rsp_tuser  = (grp_ff.nbytes != '0);
   assign rsp_tlast  = at_end;

   // a new group only lands when the previous one is finished
   assert property (@(posedge clock) disable iff (reset) load |-> load_ok)
      else $error("group loaded over pending results");

   // index never runs past the byte count
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> idx_ff <= top_ff)
      else $error("byte index beyond group");

   // a status-only result is always the single last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && idx_ff == 2'd0))
      else $error("status-only result not alone");

   // a stalled group keeps its position
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_tready) |=> (busy_ff && $stable(idx_ff)))
      else $error("byte position moved while stalled");

endmodule
